>>> hw/rtl/bfmd_pkg.sv
package bfmd_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam int PIXEL_W     = 32;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_DATA_W-1:0] RESET_SOURCE_WIDTH  = 12'd256;
   localparam logic [CSR_DATA_W-1:0] RESET_SOURCE_HEIGHT = 12'd256;

   localparam int CH8_W     = 8;
   localparam int CH8_NUM   = 4;
   localparam int CH5_W     = 5;
   localparam int CH5_NUM   = 3;
   localparam int ALPHA_BIT = 15;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIXEL_FORMAT  = 2'd0,
      CSR_SOURCE_WIDTH  = 2'd1,
      CSR_SOURCE_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic {
      FMT_ARGB8888 = 1'b0,
      FMT_ARGB1555 = 1'b1
   } format_type;

   // what an accepted pixel does once its line buffer read returns
   typedef enum logic [2:0] {
      OP_NONE,
      OP_HOLD,
      OP_STORE,
      OP_SINGLE,
      OP_ROW,
      OP_COLUMN,
      OP_BLOCK
   } op_type;

   function automatic logic [PIXEL_W-1:0] blend(
      input format_type          fmt,
      input logic [PIXEL_W-1:0]  p0,
      input logic [PIXEL_W-1:0]  p1,
      input logic [PIXEL_W-1:0]  p2,
      input logic [PIXEL_W-1:0]  p3
   );
      logic [CH8_W+1:0]   sum8;
      logic [CH5_W+1:0]   sum5;
      logic [2:0]         acnt;
      logic [PIXEL_W-1:0] r;
      r = '0;
      if (fmt == FMT_ARGB1555) begin
         for (int s = 0; s < CH5_NUM; s++) begin
            sum5 = (CH5_W+2)'(p0[s*CH5_W +: CH5_W]) + (CH5_W+2)'(p1[s*CH5_W +: CH5_W])
                 + (CH5_W+2)'(p2[s*CH5_W +: CH5_W]) + (CH5_W+2)'(p3[s*CH5_W +: CH5_W])
                 + (CH5_W+2)'(2);
            r[s*CH5_W +: CH5_W] = sum5[CH5_W+1:2];
         end
         acnt = 3'(p0[ALPHA_BIT]) + 3'(p1[ALPHA_BIT]) + 3'(p2[ALPHA_BIT])
              + 3'(p3[ALPHA_BIT]);
         r[ALPHA_BIT] = (acnt >= 3'd2);
      end else begin
         for (int s = 0; s < CH8_NUM; s++) begin
            sum8 = (CH8_W+2)'(p0[s*CH8_W +: CH8_W]) + (CH8_W+2)'(p1[s*CH8_W +: CH8_W])
                 + (CH8_W+2)'(p2[s*CH8_W +: CH8_W]) + (CH8_W+2)'(p3[s*CH8_W +: CH8_W])
                 + (CH8_W+2)'(2);
            r[s*CH8_W +: CH8_W] = sum8[CH8_W+1:2];
         end
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/bfmd_ram.sv
module bfmd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/box_filter_mip_downsample.sv
// 2x2 box filter mip level generator. Source pixels enter in raster order, one
// per clock unless stalled, and each destination pixel is registered after its
// block's lower-right pixel; an odd last column or row past the first gives no
// result. Even source rows are kept in a single line buffer with one write and one
// read port: even-row pixels are written, odd-row pixels read the two pixels
// above them over two consecutive transactions, so the memory port and the
// one-pixel pipeline set the rate. The line buffer has no clearing pass; an
// odd row must follow the even row it pairs with. The user must write geometry
// and pixel format only while no transaction is in flight; it is not enforced.
module box_filter_mip_downsample #(
   parameter int MAX_WIDTH  = bfmd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bfmd_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [bfmd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bfmd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bfmd_pkg::PIXEL_W-1:0]      req_in_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bfmd_pkg::PIXEL_W-1:0]      rsp_out_pixel,
   output logic                              rsp_row_end,
   output logic                              rsp_image_end
);

   import bfmd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WB = ($clog2(MAX_WIDTH + 1) > CSR_DATA_W) ?
                       $clog2(MAX_WIDTH + 1) : CSR_DATA_W;
   localparam int HB = ($clog2(MAX_HEIGHT + 1) > CSR_DATA_W) ?
                       $clog2(MAX_HEIGHT + 1) : CSR_DATA_W;

   function automatic logic [WB-1:0] clamp_width(input logic [CSR_DATA_W-1:0] v);
      logic [WB-1:0] ext;
      ext = WB'(v);
      if (v == '0) begin
         return WB'(1);
      end else if (ext > WB'(MAX_WIDTH)) begin
         return WB'(MAX_WIDTH);
      end
      return ext;
   endfunction

   function automatic logic [HB-1:0] clamp_height(input logic [CSR_DATA_W-1:0] v);
      logic [HB-1:0] ext;
      ext = HB'(v);
      if (v == '0) begin
         return HB'(1);
      end else if (ext > HB'(MAX_HEIGHT)) begin
         return HB'(MAX_HEIGHT);
      end
      return ext;
   endfunction

   // configuration, held already clamped
   format_type    format_ff;
   logic [WB-1:0] width_ff;
   logic [HB-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_ARGB8888;
         width_ff  <= clamp_width(RESET_SOURCE_WIDTH);
         height_ff <= clamp_height(RESET_SOURCE_HEIGHT);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PIXEL_FORMAT:  format_ff <= format_type'(csr_wdata[0]);
            CSR_SOURCE_WIDTH:  width_ff  <= clamp_width(csr_wdata);
            CSR_SOURCE_HEIGHT: height_ff <= clamp_height(csr_wdata);
            default: ;
         endcase
      end
   end

   logic          w_one, h_one;
   logic [WB-1:0] pair_cols, dw_m1;
   logic [HB-1:0] pair_rows, dh_m1;

   assign w_one     = (width_ff == WB'(1));
   assign h_one     = (height_ff == HB'(1));
   assign pair_cols = {width_ff[WB-1:1], 1'b0};
   assign pair_rows = {height_ff[HB-1:1], 1'b0};
   assign dw_m1     = (width_ff >> 1) - WB'(1);
   assign dh_m1     = (height_ff >> 1) - HB'(1);

   // source position
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WB-1:0] col_ext;
   logic [HB-1:0] row_ext;
   logic          col_last, row_last;
   logic          accept;

   assign col_ext  = WB'(col_ff);
   assign row_ext  = HB'(row_ff);
   assign accept   = req_valid && !req_stall;
   assign col_last = ({1'b0, col_ext} + (WB+1)'(1)) >= {1'b0, width_ff};
   assign row_last = ({1'b0, row_ext} + (HB+1)'(1)) >= {1'b0, height_ff};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   op_type op_dec;
   logic   row_end_dec, image_end_dec;

   always_comb begin
      op_dec = OP_NONE;
      if (h_one) begin
         if (row_ff == '0) begin
            if (w_one) begin
               if (col_ff == '0) begin
                  op_dec = OP_SINGLE;
               end
            end else if (col_ext < pair_cols) begin
               op_dec = col_ff[0] ? OP_ROW : OP_HOLD;
            end
         end
      end else if (row_ext < pair_rows) begin
         if (!row_ff[0]) begin
            op_dec = OP_STORE;
         end else if (w_one) begin
            if (col_ff == '0) begin
               op_dec = OP_COLUMN;
            end
         end else if (col_ext < pair_cols) begin
            op_dec = col_ff[0] ? OP_BLOCK : OP_HOLD;
         end
      end
   end

   assign row_end_dec   = w_one || ((col_ext >> 1) == dw_m1);
   assign image_end_dec = row_end_dec && (h_one || ((row_ext >> 1) == dh_m1));

   // line buffer: write on the even row of each row pair, read the pixel above on every transaction
   logic [PIXEL_W-1:0] line_rd;

   bfmd_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept && (op_dec == OP_STORE)),
      .wr_addr (col_ff),
      .wr_data (req_in_pixel),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   // stage 1: waits for the line buffer read
   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               s1_row_end_ff, s1_image_end_ff;
   logic               s1_emit, s1_advance;
   logic               rsp_valid_ff;

   assign s1_emit    = (s1_op_ff == OP_SINGLE) || (s1_op_ff == OP_ROW) ||
                       (s1_op_ff == OP_COLUMN) || (s1_op_ff == OP_BLOCK);
   assign s1_advance = s1_valid_ff && (!s1_emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff        <= op_dec;
         s1_pixel_ff     <= req_in_pixel;
         s1_row_end_ff   <= row_end_dec;
         s1_image_end_ff <= image_end_dec;
      end
   end

   // left pixel of the current pair and the line buffer pixel above it
   logic [PIXEL_W-1:0] held_left_ff, held_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_left_ff <= '0;
         held_top_ff  <= '0;
      end else if (s1_advance && (s1_op_ff == OP_HOLD)) begin
         held_left_ff <= s1_pixel_ff;
         held_top_ff  <= line_rd;
      end
   end

   logic [PIXEL_W-1:0] p0, p1, p2, p3;

   always_comb begin
      p0 = s1_pixel_ff;
      p1 = s1_pixel_ff;
      p2 = s1_pixel_ff;
      p3 = s1_pixel_ff;
      case (s1_op_ff)
         OP_ROW: begin
            p0 = held_left_ff;
            p2 = held_left_ff;
         end
         OP_COLUMN: begin
            p0 = line_rd;
            p1 = line_rd;
         end
         OP_BLOCK: begin
            p0 = held_top_ff;
            p1 = line_rd;
            p2 = held_left_ff;
         end
         default: ;
      endcase
   end

   // output register
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic               rsp_row_end_ff, rsp_image_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_emit) begin
         rsp_pixel_ff     <= blend(format_ff, p0, p1, p2, p3);
         rsp_row_end_ff   <= s1_row_end_ff;
         rsp_image_end_ff <= s1_image_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_image_end = rsp_image_end_ff;

endmodule

>>> hw/rtl/bfmd_checker.sv
module bfmd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [bfmd_pkg::PIXEL_W-1:0]      rsp_out_pixel,
   input logic                              rsp_row_end,
   input logic                              rsp_image_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_pixel) && $stable(rsp_row_end)
                                 && $stable(rsp_image_end))
      else $error("rsp payload changed while stalled");

   a_image_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_row_end)
      else $error("image end without row end");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind box_filter_mip_downsample bfmd_checker u_bfmd_checker (.*);

>>> bench/box_filter_mip_downsample_test.sv
`timescale 1ns / 1ps

module box_filter_mip_downsample_test;

   import bfmd_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
      logic               image_end;
   } mip_pixel_type;

   class mip_scoreboard;
      localparam int MAX_W = DEF_MAX_WIDTH;
      localparam int MAX_H = DEF_MAX_HEIGHT;

      logic [PIXEL_W-1:0]    line_buf [MAX_W];
      logic [PIXEL_W-1:0]    left_pixel;
      int unsigned           col;
      int unsigned           row;
      format_type            fmt;
      logic [CSR_DATA_W-1:0] width_reg;
      logic [CSR_DATA_W-1:0] height_reg;
      mip_pixel_type         expected[$];
      int                    mismatches;

      function new();
         foreach (line_buf[i]) line_buf[i] = '0;
         left_pixel = '0;
         col = 0;
         row = 0;
         fmt = FMT_ARGB8888;
         width_reg = RESET_SOURCE_WIDTH;
         height_reg = RESET_SOURCE_HEIGHT;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_PIXEL_FORMAT:  fmt = format_type'(value[0]);
            CSR_SOURCE_WIDTH:  width_reg = value;
            CSR_SOURCE_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      static function int unsigned limit_dim(logic [CSR_DATA_W-1:0] v, int unsigned top);
         if (v == 0) return 1;
         return (v > top) ? top : int'(v);
      endfunction

      function logic [PIXEL_W-1:0] average(input logic [PIXEL_W-1:0] a, b, c, d);
         logic [PIXEL_W-1:0] r;
         int unsigned        sum;
         int unsigned        ones;
         r = '0;
         if (fmt == FMT_ARGB1555) begin
            for (int ch = 0; ch < CH5_NUM; ch++) begin
               sum = a[ch*CH5_W +: CH5_W] + b[ch*CH5_W +: CH5_W] + c[ch*CH5_W +: CH5_W]
                   + d[ch*CH5_W +: CH5_W] + 2;
               r[ch*CH5_W +: CH5_W] = CH5_W'(sum >> 2);
            end
            ones = a[ALPHA_BIT] + b[ALPHA_BIT] + c[ALPHA_BIT] + d[ALPHA_BIT];
            r[ALPHA_BIT] = (ones >= 2);
         end else begin
            for (int ch = 0; ch < CH8_NUM; ch++) begin
               sum = a[ch*CH8_W +: CH8_W] + b[ch*CH8_W +: CH8_W] + c[ch*CH8_W +: CH8_W]
                   + d[ch*CH8_W +: CH8_W] + 2;
               r[ch*CH8_W +: CH8_W] = CH8_W'(sum >> 2);
            end
         end
         return r;
      endfunction

      function void note_input(logic [PIXEL_W-1:0] px);
         int unsigned        w, h, dw, dh, x, y;
         logic [PIXEL_W-1:0] res;
         bit                 emit;
         w = limit_dim(width_reg, MAX_W);
         h = limit_dim(height_reg, MAX_H);
         dw = (w > 1) ? w / 2 : 1;
         dh = (h > 1) ? h / 2 : 1;
         x = 0;
         y = 0;
         res = '0;
         emit = 0;
         if (h == 1) begin
            if (row == 0) begin
               if (w == 1) begin
                  if (col == 0) begin
                     res = average(px, px, px, px);
                     emit = 1;
                  end
               end else if (col < 2 * dw) begin
                  if (col % 2 == 0) left_pixel = px;
                  else begin
                     res = average(left_pixel, px, left_pixel, px);
                     x = col / 2;
                     emit = 1;
                  end
               end
            end
         end else if (row < 2 * dh) begin
            y = row / 2;
            if (row % 2 == 0) begin
               if (col < MAX_W) line_buf[col] = px;
            end else if (w == 1) begin
               if (col == 0) begin
                  res = average(line_buf[0], line_buf[0], px, px);
                  emit = 1;
               end
            end else if (col < 2 * dw) begin
               if (col % 2 == 0) left_pixel = px;
               else begin
                  res = average(line_buf[col-1], line_buf[col], left_pixel, px);
                  x = col / 2;
                  emit = 1;
               end
            end
         end
         if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
         end else begin
            col++;
         end
         if (emit)
            expected.push_back('{pixel: res, row_end: (x == dw - 1),
                                 image_end: (x == dw - 1) && (y == dh - 1)});
      endfunction

      task log_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_result(logic [PIXEL_W-1:0] px, logic re, logic ie);
         mip_pixel_type want;
         if (expected.size() == 0) begin
            log_mismatch($sformatf("unexpected pixel %h row_end %b image_end %b",
                                   px, re, ie));
            return;
         end
         want = expected.pop_front();
         if (px !== want.pixel || re !== want.row_end || ie !== want.image_end)
            log_mismatch($sformatf("pixel %h row_end %b image_end %b, want %h %b %b",
                                   px, re, ie, want.pixel, want.row_end, want.image_end));
      endtask

      function int pending();
         return expected.size();
      endfunction
   endclass

   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PIXELS = 800;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_in_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]     rsp_out_pixel;
   logic                   rsp_row_end;
   logic                   rsp_image_end;

   mip_scoreboard sb;
   int unsigned   pixels_sent = 0;
   int unsigned   burst_left = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   stall_cycle = 0;
   int unsigned   run_left = 0;
   bit            gaps_on = 0;
   bit            run_val = 0;
   bit            stall_next = 0;

   always #4 clock = ~clock;

   box_filter_mip_downsample u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_pixel  (req_in_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_row_end   (rsp_row_end),
      .rsp_image_end (rsp_image_end)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_pixel, rsp_row_end, rsp_image_end);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver backpressure: free-flowing, light, long runs, heavy
   always @(negedge clock) begin
      stall_cycle++;
      case (stall_cycle[8:7])
         2'd0: stall_next = 1'b0;
         2'd1: stall_next = ($urandom_range(0, 3) == 0);
         2'd2: begin
            if (run_left == 0) begin
               run_val = $urandom_range(0, 1);
               run_left = $urandom_range(1, 12);
            end
            run_left--;
            stall_next = run_val;
         end
         default: stall_next = ($urandom_range(0, 3) != 0);
      endcase
      rsp_stall <= stall_next;
   end

   function automatic logic [PIXEL_W-1:0] random_pixel();
      logic [PIXEL_W-1:0] p;
      case ($urandom_range(0, 7))
         0: p = '0;
         1: p = '1;
         2: begin
            p = $urandom;
            for (int i = 0; i < 4; i++) p[i*8 +: 8] = {8{p[i*8]}};
         end
         default: p = $urandom;
      endcase
      return p;
   endfunction

   function automatic int unsigned random_dim(input int unsigned hi);
      case ($urandom_range(0, 15))
         0: return 0;
         1: return 1;
         2: return $urandom_range(hi / 2, hi);
         default: return $urandom_range(2, 10);
      endcase
   endfunction

   task automatic put_pixel(input logic [PIXEL_W-1:0] px);
      @(negedge clock);
      req_valid <= 1'b1;
      req_in_pixel <= px;
      do @(posedge clock); while (req_stall);
      sb.note_input(px);
      pixels_sent++;
   endtask

   task automatic hold_off(input int unsigned n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic feed(input logic [PIXEL_W-1:0] px);
      if (burst_left == 0) begin
         if (gaps_on) hold_off($urandom_range(1, 6));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      put_pixel(px);
   endtask

   // feeds pixels until the position counters are back at the image start
   task automatic feed_image();
      do feed(random_pixel()); while (sb.col != 0 || sb.row != 0);
   endtask

   task automatic drain();
      hold_off(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(input format_type f, input int unsigned w, input int unsigned h);
      drain();
      write_csr(CSR_PIXEL_FORMAT, CSR_DATA_W'(f));
      write_csr(CSR_SOURCE_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_SOURCE_HEIGHT, CSR_DATA_W'(h));
   endtask

   initial begin
      int unsigned first_random;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(FMT_ARGB8888, 2, 2);
      put_pixel('0);
      put_pixel('1);
      put_pixel('1);
      put_pixel('1);
      configure(FMT_ARGB1555, 2, 2);
      put_pixel(32'h0000_ffff);
      put_pixel(32'hffff_8000);
      put_pixel(32'h0000_0000);
      put_pixel(32'h1234_7fff);
      configure(FMT_ARGB8888, 1, 1);
      put_pixel(32'h80ff_0001);
      // zero dimensions behave as one
      configure(FMT_ARGB1555, 0, 0);
      put_pixel(32'hdead_beef);
      configure(FMT_ARGB8888, 3, 1);
      repeat (3) put_pixel(random_pixel());
      configure(FMT_ARGB8888, 1, 3);
      repeat (3) put_pixel(random_pixel());
      // shrink width and flip format partway through an image
      configure(FMT_ARGB8888, 4, 4);
      repeat (6) put_pixel(random_pixel());
      drain();
      write_csr(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_ARGB1555));
      write_csr(CSR_SOURCE_WIDTH, CSR_DATA_W'(2));
      feed_image();

      // oversized geometry, cut short by shrinking it partway through
      gaps_on = 1;
      configure(FMT_ARGB8888, 4095, 1);
      repeat (40) feed(random_pixel());
      drain();
      write_csr(CSR_SOURCE_WIDTH, CSR_DATA_W'(2));
      feed_image();
      configure(FMT_ARGB1555, 1, 4095);
      repeat (30) feed(random_pixel());
      drain();
      write_csr(CSR_SOURCE_HEIGHT, CSR_DATA_W'(2));
      feed_image();

      first_random = pixels_sent;
      while (pixels_sent - first_random < RANDOM_PIXELS) begin
         configure(format_type'($urandom_range(0, 1)), random_dim(48), random_dim(12));
         gaps_on = ($urandom_range(0, 2) != 0);
         burst_left = 0;
         repeat ($urandom_range(1, 3)) feed_image();
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) feed(random_pixel());
            drain();
            write_csr(CSR_PIXEL_FORMAT, CSR_DATA_W'(~sb.fmt));
            feed_image();
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
